/* hdl/node_liveness_table_assert.svh */
// assertion macros for the node liveness table checker
`ifndef NODE_LIVENESS_TABLE_ASSERT_SVH
`define NODE_LIVENESS_TABLE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define NLT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define NLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/nlt_pkg.sv */
// shared types, constants and helpers of the node liveness table
package nlt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int OUT_LIMIT = 16;
	localparam int CNT_W = $clog2(OUT_LIMIT + 1);
	localparam int SLOT_W = 4;
	localparam int CFG_W = 32;

	typedef enum logic [1:0] {
		ACT_REGISTER = 2'd0,
		ACT_BEAT     = 2'd1,
		ACT_STATUS   = 2'd2,
		ACT_CHECK    = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		KIND_REGISTERED  = 3'd0,
		KIND_FULL        = 3'd1,
		KIND_BEAT_STORED = 3'd2,
		KIND_BEAT_UNK    = 3'd3,
		KIND_STAT_STORED = 3'd4,
		KIND_STAT_UNK    = 3'd5,
		KIND_OFFLINE     = 3'd6,
		KIND_NONE        = 3'd7
	} kind_t;

	typedef enum logic [0:0] {
		CFG_TIMEOUT    = 1'd0,
		CFG_STATE_CODE = 1'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		EMIT_HIT   = 2'd0,
		EMIT_PEND  = 2'd1,
		EMIT_FINAL = 2'd2
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      step;
		logic      apply;
		logic      emit;
		emit_sel_t sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic hit;
		logic at_end;
		logic out_free;
		logic pend_valid;
		logic is_check;
	} dp_stat_t;

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
		logic [IDX_W+SLOT_W-1:0] ext;
		ext = {{SLOT_W{1'b0}}, idx};
		return ext[SLOT_W-1:0];
	endfunction

endpackage

/* hdl/node_liveness_table.sv */
// node liveness table: top level joining the sequencer and the table datapath
// an item is taken while idle, then the table is scanned one entry per cycle
// register, heartbeat and status stop at the first matching slot
// an offline check walks all 16 slots, emits one word per dropped node or a none word
// the scan of one entry per cycle sets the rate; output stalls hold the scan
// reset clears all entries offline, stamps to zero, timeout 1000, state code 0
module node_liveness_table import nlt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [31:0]         now_ticks,
	input  logic [7:0]          node_id,
	input  logic [7:0]          node_kind,
	input  logic signed [15:0]  speed_rpm,
	input  logic [15:0]         drive_pwm,
	input  logic [7:0]          node_state,
	input  logic [7:0]          fault,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          kind,
	output logic [7:0]          result_node,
	output logic [SLOT_W-1:0]   slot,
	output logic                last
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	nlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	nlt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (action),
		.now_ticks   (now_ticks),
		.node_id     (node_id),
		.node_kind   (node_kind),
		.speed_rpm   (speed_rpm),
		.drive_pwm   (drive_pwm),
		.node_state  (node_state),
		.fault       (fault),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.result_node (result_node),
		.slot        (slot),
		.last        (last)
	);

endmodule

/* hdl/nlt_ctrl.sv */
// sequencer for the table scan of each word
module nlt_ctrl import nlt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.sel  = EMIT_HIT;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.is_check) begin
					if (stat.hit && stat.pend_valid && !stat.out_free) begin
						state_d = ST_SCAN;
					end else begin
						cmd.apply = stat.hit;
						cmd.emit  = stat.hit && stat.pend_valid;
						cmd.sel   = EMIT_PEND;
						if (stat.at_end) begin
							state_d = ST_DONE;
						end else begin
							cmd.step = 1'b1;
						end
					end
				end else if (stat.hit) begin
					if (stat.out_free) begin
						cmd.apply = 1'b1;
						cmd.emit  = 1'b1;
						cmd.sel   = EMIT_HIT;
						state_d   = ST_IDLE;
					end
				end else if (stat.at_end) begin
					state_d = ST_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = EMIT_FINAL;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hdl/nlt_dp.sv */
// node table storage, scan index, match logic and result register
module nlt_dp import nlt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_cmd_t            cmd,
	output dp_stat_t            stat,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic [1:0]          action,
	input  logic [31:0]         now_ticks,
	input  logic [7:0]          node_id,
	input  logic [7:0]          node_kind,
	input  logic signed [15:0]  speed_rpm,
	input  logic [15:0]         drive_pwm,
	input  logic [7:0]          node_state,
	input  logic [7:0]          fault,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          kind,
	output logic [7:0]          result_node,
	output logic [SLOT_W-1:0]   slot,
	output logic                last
);

	logic [31:0] timeout_q;
	logic [7:0]  off_code_q;

	act_t        act_q;
	logic [31:0] now_q;
	logic [7:0]  id_q;
	logic [7:0]  nkind_q;
	logic [15:0] rpm_q;
	logic [15:0] pwm_q;
	logic [7:0]  nstate_q;
	logic [7:0]  nfault_q;

	logic [TABLE_DEPTH-1:0] online_q;
	logic [7:0]  node_q  [TABLE_DEPTH];
	logic [7:0]  ekind_q [TABLE_DEPTH];
	logic [31:0] stamp_q [TABLE_DEPTH];
	logic [15:0] speed_q [TABLE_DEPTH];
	logic [15:0] epwm_q  [TABLE_DEPTH];
	logic [7:0]  state_q [TABLE_DEPTH];
	logic [7:0]  efault_q[TABLE_DEPTH];

	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_valid_q;
	logic [7:0]       pend_node_q;
	logic [SLOT_W-1:0] pend_slot_q;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  node_out_q;
	logic [SLOT_W-1:0] slot_q;
	logic        last_q;

	logic        cur_online;
	logic [7:0]  cur_node;
	logic [31:0] cur_age;
	logic        hit;
	kind_t       hit_kind;
	kind_t       fail_kind;
	kind_t       kind_d;
	logic [7:0]  node_d;
	logic [SLOT_W-1:0] slot_d;
	logic        last_d;

	assign cur_online = online_q[idx_q];
	assign cur_node   = node_q[idx_q];
	assign cur_age    = now_q - stamp_q[idx_q];

	always_comb begin
		hit       = 1'b0;
		hit_kind  = KIND_REGISTERED;
		fail_kind = KIND_FULL;
		unique case (act_q)
			ACT_REGISTER: begin
				hit       = !cur_online;
				hit_kind  = KIND_REGISTERED;
				fail_kind = KIND_FULL;
			end
			ACT_BEAT: begin
				hit       = cur_online && (cur_node == id_q);
				hit_kind  = KIND_BEAT_STORED;
				fail_kind = KIND_BEAT_UNK;
			end
			ACT_STATUS: begin
				hit       = cur_online && (cur_node == id_q);
				hit_kind  = KIND_STAT_STORED;
				fail_kind = KIND_STAT_UNK;
			end
			ACT_CHECK: begin
				hit       = cur_online && (cur_age > timeout_q) &&
					(cnt_q != CNT_W'(OUT_LIMIT));
				hit_kind  = KIND_OFFLINE;
				fail_kind = KIND_NONE;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	assign stat.hit        = hit;
	assign stat.at_end     = (idx_q == IDX_W'(TABLE_DEPTH - 1));
	assign stat.out_free   = !out_valid_q || !out_stall;
	assign stat.pend_valid = pend_valid_q;
	assign stat.is_check   = (act_q == ACT_CHECK);

	always_comb begin
		kind_d = hit_kind;
		node_d = id_q;
		slot_d = to_slot(idx_q);
		last_d = 1'b1;
		unique case (cmd.sel)
			EMIT_HIT: begin
				kind_d = hit_kind;
			end
			EMIT_PEND: begin
				kind_d = KIND_OFFLINE;
				node_d = pend_node_q;
				slot_d = pend_slot_q;
				last_d = 1'b0;
			end
			EMIT_FINAL: begin
				if (pend_valid_q) begin
					kind_d = KIND_OFFLINE;
					node_d = pend_node_q;
					slot_d = pend_slot_q;
				end else begin
					kind_d = fail_kind;
					slot_d = '0;
				end
			end
			default: begin
				kind_d = fail_kind;
				slot_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= 32'd1000;
			off_code_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TIMEOUT:    timeout_q  <= cfg_data[31:0];
				CFG_STATE_CODE: off_code_q <= cfg_data[7:0];
				default:        timeout_q  <= timeout_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= act_t'(action);
			now_q    <= now_ticks;
			id_q     <= node_id;
			nkind_q  <= node_kind;
			rpm_q    <= $unsigned(speed_rpm);
			pwm_q    <= drive_pwm;
			nstate_q <= node_state;
			nfault_q <= fault;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.load) begin
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.apply && (act_q == ACT_CHECK)) begin
				cnt_q        <= cnt_q + 1'b1;
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && (act_q == ACT_CHECK)) begin
			pend_node_q <= cur_node;
			pend_slot_q <= to_slot(idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			online_q <= '0;
		end else if (cmd.apply) begin
			if (act_q == ACT_REGISTER) begin
				online_q[idx_q] <= 1'b1;
			end else if (act_q == ACT_CHECK) begin
				online_q[idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				stamp_q[i] <= '0;
			end
		end else if (cmd.apply && (act_q == ACT_BEAT)) begin
			stamp_q[idx_q] <= now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			unique case (act_q)
				ACT_REGISTER: begin
					node_q[idx_q]  <= id_q;
					ekind_q[idx_q] <= nkind_q;
				end
				ACT_STATUS: begin
					speed_q[idx_q]  <= rpm_q;
					epwm_q[idx_q]   <= pwm_q;
					state_q[idx_q]  <= nstate_q;
					efault_q[idx_q] <= nfault_q;
				end
				ACT_CHECK: begin
					state_q[idx_q] <= off_code_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q     <= kind_d;
			node_out_q <= node_d;
			slot_q     <= slot_d;
			last_q     <= last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign result_node = node_out_q;
	assign slot        = slot_q;
	assign last        = last_q;

endmodule

/* hdl/nlt_checker.sv */
// port-level assertions of the node liveness table and their bind
`include "node_liveness_table_assert.svh"

module nlt_checker import nlt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [2:0]        kind,
	input logic [7:0]        result_node,
	input logic [SLOT_W-1:0] slot,
	input logic              last
);

	`NLT_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input taken while busy")
	`NLT_ASSERT_NOW(a_single_is_last, out_valid && (kind != KIND_OFFLINE), last, "single word not last")
	`NLT_ASSERT_NOW(a_fail_slot_zero, out_valid && (kind == KIND_FULL || kind == KIND_BEAT_UNK || kind == KIND_STAT_UNK || kind == KIND_NONE), slot == '0, "failure word with slot")
	`NLT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(result_node) && $stable(slot) && $stable(last), "stalled word changed")

endmodule

bind node_liveness_table nlt_checker u_nlt_checker (.*);

/* tb/sv/node_liveness_table_test.sv */
// testbench for the node liveness table: directed and random words checked against a table tracker
module node_liveness_table_test;
	timeunit 1ns;
	timeprecision 1ps;
	import nlt_pkg::*;

	typedef struct {
		act_t               action;
		logic [31:0]        now;
		logic [7:0]         id;
		logic [7:0]         nkind;
		logic signed [15:0] rpm;
		logic [15:0]        pwm;
		logic [7:0]         nstate;
		logic [7:0]         nfault;
	} node_msg_t;

	typedef struct {
		kind_t             kind;
		logic [7:0]        node;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} report_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [0:0]         cfg_index = CFG_TIMEOUT;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         action = ACT_REGISTER;
	logic [31:0]        now_ticks = '0;
	logic [7:0]         node_id = '0;
	logic [7:0]         node_kind = '0;
	logic signed [15:0] speed_rpm = '0;
	logic [15:0]        drive_pwm = '0;
	logic [7:0]         node_state = '0;
	logic [7:0]         fault = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         kind;
	logic [7:0]         result_node;
	logic [SLOT_W-1:0]  slot;
	logic               last;

	node_liveness_table dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .now_ticks(now_ticks), .node_id(node_id), .node_kind(node_kind),
		.speed_rpm(speed_rpm), .drive_pwm(drive_pwm), .node_state(node_state), .fault(fault),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .result_node(result_node), .slot(slot), .last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// tracked copy of the table and its settings
	logic        tbl_online [TABLE_DEPTH];
	logic [7:0]  tbl_node   [TABLE_DEPTH];
	logic [7:0]  tbl_kind   [TABLE_DEPTH];
	logic [31:0] tbl_stamp  [TABLE_DEPTH];
	logic [15:0] tbl_speed  [TABLE_DEPTH];
	logic [15:0] tbl_pwm    [TABLE_DEPTH];
	logic [7:0]  tbl_state  [TABLE_DEPTH];
	logic [7:0]  tbl_fault  [TABLE_DEPTH];
	logic [31:0] age_limit = 32'd1000;
	logic [7:0]  drop_state = 8'd0;

	node_msg_t pending_msgs[$];
	report_t   expected_reports[$];
	node_msg_t on_bus;

	int send_idle_pct = 15;
	int recv_stall_pct = 60;
	int fail_count = 0;
	int words_sent = 0;
	int reports_seen = 0;
	int offline_seen = 0;
	int full_seen = 0;

	logic [31:0] gen_tick = '0;
	int unsigned tick_step = 100;
	logic [7:0]  id_pool [8];

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tbl_online[i] = 1'b0;
			tbl_node[i] = '0;
			tbl_kind[i] = '0;
			tbl_stamp[i] = '0;
			tbl_speed[i] = '0;
			tbl_pwm[i] = '0;
			tbl_state[i] = '0;
			tbl_fault[i] = '0;
		end
	end

	function automatic void push_report(kind_t k, logic [7:0] node, int s, logic lst);
		report_t r;
		r.kind = k;
		r.node = node;
		r.slot = s[SLOT_W-1:0];
		r.last = lst;
		expected_reports.push_back(r);
	endfunction

	function automatic int find_live(logic [7:0] id);
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (tbl_online[i] && tbl_node[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void update_table(node_msg_t m);
		int          hit;
		int          n;
		int          last_hit;
		logic [31:0] age;
		logic        expired [TABLE_DEPTH];
		hit = -1;
		case (m.action)
			ACT_REGISTER: begin
				for (int i = 0; i < TABLE_DEPTH; i++)
					if (!tbl_online[i] && hit < 0)
						hit = i;
				if (hit >= 0) begin
					tbl_online[hit] = 1'b1;
					tbl_node[hit] = m.id;
					tbl_kind[hit] = m.nkind;
					push_report(KIND_REGISTERED, m.id, hit, 1'b1);
				end else begin
					push_report(KIND_FULL, m.id, 0, 1'b1);
				end
			end
			ACT_BEAT: begin
				hit = find_live(m.id);
				if (hit >= 0) begin
					tbl_stamp[hit] = m.now;
					push_report(KIND_BEAT_STORED, m.id, hit, 1'b1);
				end else begin
					push_report(KIND_BEAT_UNK, m.id, 0, 1'b1);
				end
			end
			ACT_STATUS: begin
				hit = find_live(m.id);
				if (hit >= 0) begin
					tbl_speed[hit] = m.rpm;
					tbl_pwm[hit] = m.pwm;
					tbl_state[hit] = m.nstate;
					tbl_fault[hit] = m.nfault;
					push_report(KIND_STAT_STORED, m.id, hit, 1'b1);
				end else begin
					push_report(KIND_STAT_UNK, m.id, 0, 1'b1);
				end
			end
			default: begin
				n = 0;
				last_hit = -1;
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					age = m.now - tbl_stamp[i];
					expired[i] = tbl_online[i] && age > age_limit && n < OUT_LIMIT;
					if (expired[i]) begin
						n++;
						last_hit = i;
					end
				end
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (expired[i]) begin
						tbl_online[i] = 1'b0;
						tbl_state[i] = drop_state;
						push_report(KIND_OFFLINE, tbl_node[i], i, i == last_hit);
					end
				end
				if (n == 0)
					push_report(KIND_NONE, m.id, 0, 1'b1);
			end
		endcase
	endfunction

	function automatic node_msg_t msg(act_t a, logic [31:0] now, logic [7:0] id,
			logic [7:0] nkind, logic [15:0] rpm, logic [15:0] pwm,
			logic [7:0] nstate, logic [7:0] nfault);
		node_msg_t m;
		m.action = a;
		m.now = now;
		m.id = id;
		m.nkind = nkind;
		m.rpm = rpm;
		m.pwm = pwm;
		m.nstate = nstate;
		m.nfault = nfault;
		return m;
	endfunction

	function automatic node_msg_t random_msg();
		node_msg_t m;
		int        roll;
		roll = $urandom_range(99);
		if (roll < 5)
			gen_tick = $urandom();
		else
			gen_tick = gen_tick + $urandom_range(tick_step);
		// occasional stale or out-of-order tick
		m.now = ($urandom_range(99) < 5) ? 32'($urandom()) : gen_tick;
		roll = $urandom_range(99);
		if (roll < 30)
			m.action = ACT_REGISTER;
		else if (roll < 60)
			m.action = ACT_BEAT;
		else if (roll < 80)
			m.action = ACT_STATUS;
		else
			m.action = ACT_CHECK;
		m.id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(7)] : 8'($urandom());
		m.nkind = 8'($urandom());
		m.rpm = 16'($urandom());
		m.pwm = 16'($urandom());
		m.nstate = 8'($urandom());
		m.nfault = 8'($urandom());
		return m;
	endfunction

	// word driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				update_table(on_bus);
				words_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_msgs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = pending_msgs.pop_front();
					in_valid <= 1'b1;
					action <= on_bus.action;
					now_ticks <= on_bus.now;
					node_id <= on_bus.id;
					node_kind <= on_bus.nkind;
					speed_rpm <= on_bus.rpm;
					drive_pwm <= on_bus.pwm;
					node_state <= on_bus.nstate;
					fault <= on_bus.nfault;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		report_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				reports_seen++;
				if (kind == KIND_OFFLINE)
					offline_seen++;
				if (kind == KIND_FULL)
					full_seen++;
				if (expected_reports.size() == 0) begin
					$error("unexpected word: kind %0d node %0d slot %0d last %0d",
						kind, result_node, slot, last);
					fail_count++;
				end else begin
					exp_r = expected_reports.pop_front();
					if (kind !== exp_r.kind) begin
						$error("kind: expected %0d, actual %0d", exp_r.kind, kind);
						fail_count++;
					end
					if (result_node !== exp_r.node) begin
						$error("result_node: expected %0d, actual %0d", exp_r.node, result_node);
						fail_count++;
					end
					if (slot !== exp_r.slot) begin
						$error("slot: expected %0d, actual %0d", exp_r.slot, slot);
						fail_count++;
					end
					if (last !== exp_r.last) begin
						$error("last: expected %0d, actual %0d", exp_r.last, last);
						fail_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_TIMEOUT)
			age_limit = val;
		else
			drop_state = val[7:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_msgs.size() != 0 || in_valid || expected_reports.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic run_random(int count, int unsigned step);
		id_pool[0] = 8'h00;
		id_pool[1] = 8'hFF;
		for (int i = 2; i < 8; i++)
			id_pool[i] = 8'($urandom());
		tick_step = step;
		repeat (count) pending_msgs.push_back(random_msg());
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings, timeout 1000
		pending_msgs.push_back(msg(ACT_CHECK, 32'd0, 8'hAB, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0));
		pending_msgs.push_back(msg(ACT_BEAT, 32'd5, 8'hFF, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0));
		pending_msgs.push_back(msg(ACT_STATUS, 32'd5, 8'h00, 8'd0, 16'd1, 16'd1, 8'd1, 8'd1));
		pending_msgs.push_back(msg(ACT_REGISTER, 32'd0, 8'h00, 8'h00, 16'd0, 16'd0, 8'd0, 8'd0));
		pending_msgs.push_back(msg(ACT_REGISTER, 32'd0, 8'hFF, 8'hFF, 16'd0, 16'd0, 8'd0, 8'd0));
		pending_msgs.push_back(msg(ACT_REGISTER, 32'd0, 8'h07, 8'h00, 16'd0, 16'd0, 8'd0, 8'd0));
		// same id again takes a fresh slot
		pending_msgs.push_back(msg(ACT_REGISTER, 32'd0, 8'h07, 8'hFF, 16'd0, 16'd0, 8'd0, 8'd0));
		for (int i = 0; i < 12; i++)
			pending_msgs.push_back(msg(ACT_REGISTER, 32'd0, 8'(10 + i), 8'(i * 21),
				16'd0, 16'd0, 8'd0, 8'd0));
		// table full
		pending_msgs.push_back(msg(ACT_REGISTER, 32'd0, 8'd99, 8'd3, 16'd0, 16'd0, 8'd0, 8'd0));
		pending_msgs.push_back(msg(ACT_BEAT, 32'hFFFF_FFFF, 8'hFF, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0));
		pending_msgs.push_back(msg(ACT_BEAT, 32'd2000, 8'h07, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0));
		pending_msgs.push_back(msg(ACT_STATUS, 32'd0, 8'h00, 8'd0, 16'h8000, 16'hFFFF,
			8'hFF, 8'hFF));
		pending_msgs.push_back(msg(ACT_STATUS, 32'd0, 8'h07, 8'd0, 16'h7FFF, 16'h0000,
			8'h00, 8'h00));
		// wrapped ages drop two, age equal to the timeout keeps the rest
		pending_msgs.push_back(msg(ACT_CHECK, 32'd1000, 8'd1, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0));
		pending_msgs.push_back(msg(ACT_CHECK, 32'h8000_0000, 8'd2, 8'd0, 16'd0, 16'd0,
			8'd0, 8'd0));
		pending_msgs.push_back(msg(ACT_REGISTER, 32'd0, 8'h07, 8'h55, 16'd0, 16'd0, 8'd0, 8'd0));
		wait_drained();

		write_reg(CFG_TIMEOUT, 32'd0);
		write_reg(CFG_STATE_CODE, 32'd255);
		run_random(29, 3);

		send_idle_pct = 60;
		recv_stall_pct = 15;
		write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(CFG_STATE_CODE, 32'd0);
		run_random(29, 1000);

		write_reg(CFG_TIMEOUT, $urandom_range(400, 50));
		write_reg(CFG_STATE_CODE, $urandom_range(255));
		run_random(29, 120);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(CFG_TIMEOUT, $urandom());
		write_reg(CFG_STATE_CODE, $urandom_range(255));
		run_random(29, 32'h2000_0000);

		write_reg(CFG_TIMEOUT, 32'd1000);
		run_random(29, 400);

		$display("covered %0d input words and %0d result words over six timeout settings",
			words_sent, reports_seen);
		$display("including %0d offline drops and %0d full-table refusals",
			offline_seen, full_seen);
		if (fail_count == 0 && expected_reports.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/nlt_pkg.sv
hdl/nlt_ctrl.sv
hdl/nlt_dp.sv
hdl/node_liveness_table.sv
hdl/nlt_checker.sv
tb/sv/node_liveness_table_test.sv
